@@ rtl/core/brf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the byte ring FIFO.
// No dependencies; used by the channel interfaces and the top level.
package brf_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CAP_W    = 11;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned PADDR_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // byte address of the capacity_in_use register
  localparam logic [PADDR_W-1:0] ADDR_CAP_IN_USE = 2'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_TAIL  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP        = 3'd2,
    CMD_PEEK       = 3'd3,
    CMD_SKIP       = 3'd4,
    CMD_CLEAR      = 3'd5,
    CMD_STATUS     = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

@@ rtl/core/brf_in_if.sv @@
`timescale 1ns / 1ps
// Command channel of the byte ring FIFO: valid/ready plus one command item.
// Depends on brf_pkg for field widths.
interface brf_in_if import brf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [BYTE_W-1:0]     data_byte;
  logic [COUNT_W-1:0]    peek_offset;
  logic [COUNT_W-1:0]    skip_count;

  modport source (output valid, cmd, data_byte, peek_offset, skip_count, input ready);
  modport sink   (input valid, cmd, data_byte, peek_offset, skip_count, output ready);
endinterface

@@ rtl/core/brf_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the byte ring FIFO: valid/ready plus one result item.
// Depends on brf_pkg for field widths.
interface brf_out_if import brf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [BYTE_W-1:0]     data_out;
  logic [COUNT_W-1:0]    bytes_skipped;
  logic [COUNT_W-1:0]    used_count;
  logic [COUNT_W-1:0]    free_count;

  modport source (output valid, status, data_out, bytes_skipped, used_count, free_count,
                  input ready);
  modport sink   (input valid, status, data_out, bytes_skipped, used_count, free_count,
                  output ready);
endinterface

@@ rtl/core/brf_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/byte_ring_fifo_with_putback_peek.sv @@
`timescale 1ns / 1ps
// Byte ring FIFO with push-front (put back), pop, peek at an offset, skip, clear and status.
// Takes one command per clock; its result appears in the cycle after acceptance, and a new
// command is taken whenever the result register is empty or being drained, so the rate is
// one item per cycle. The registered read of the byte store lands in the same cycle as the
// result register, so a pop or peek returns its byte together with its result; the input
// stalls only while a result waits for the consumer.
// A write to capacity_in_use (APB, address 0) empties the ring; capacity 0 acts as 1 and
// values above STORE_DEPTH act as STORE_DEPTH. There is no clearing pass after reset: only
// bytes that were pushed are ever read. Depends on brf_pkg, brf_in_if, brf_out_if, brf_ram.
module byte_ring_fifo_with_putback_peek import brf_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  brf_in_if.sink             in_i,
  brf_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned SW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned XW = (SW > COUNT_W) ? SW : COUNT_W;

  logic [CAP_W-1:0]    cap_q;
  logic [AW-1:0]       rp_q, rp_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [SW-1:0]       cap_eff;
  logic [SW-1:0]       used_c, free_c, used_n;
  logic [XW-1:0]       skipped_c;
  logic [AW-1:0]       peek_addr;
  logic                cfg_we;
  logic                accept;

  logic                out_valid_q;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [XW-1:0]       res_skipped_q;
  logic [SW-1:0]       res_used_q, res_free_q;
  logic                res_rd_q, res_rd_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  // (p + n) mod cap, valid while p < cap and n <= cap
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [XW-1:0] n,
                                             input logic [SW-1:0] cap);
    logic [XW:0] sum;
    sum = (XW+1)'(p) + (XW+1)'(n);
    if (sum >= (XW+1)'(cap)) begin
      sum = sum - (XW+1)'(cap);
    end
    return AW'(sum);
  endfunction

  // ---------------- configuration ----------------
  assign cfg_we = psel && penable && pwrite && (paddr == ADDR_CAP_IN_USE);
  assign pready = 1'b1;
  assign prdata = PDATA_W'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = SW'(1);
    end else if (32'(cap_q) > 32'(STORE_DEPTH)) begin
      cap_eff = SW'(STORE_DEPTH);
    end else begin
      cap_eff = SW'(cap_q);
    end
  end

  // ---------------- occupancy ----------------
  always_comb begin
    if (wp_q >= rp_q) begin
      used_c = SW'(wp_q) - SW'(rp_q);
    end else begin
      used_c = SW'(wp_q) + cap_eff - SW'(rp_q);
    end
  end

  assign free_c    = cap_eff - used_c - SW'(1);
  assign skipped_c = (XW'(in_i.skip_count) > XW'(used_c)) ? XW'(used_c) : XW'(in_i.skip_count);
  assign peek_addr = wrap_add(rp_q, XW'(in_i.peek_offset), cap_eff);

  // ---------------- command decode ----------------
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    rp_d         = rp_q;
    wp_d         = wp_q;
    res_status_d = ST_OK;
    res_rd_d     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = wp_q;
    ram_raddr    = rp_q;
    unique case (cmd_e'(in_i.cmd))
      CMD_PUSH_TAIL: begin
        if (free_c == '0) begin
          res_status_d = ST_FULL;
        end else begin
          ram_we = 1'b1;
          wp_d   = wrap_add(wp_q, XW'(1), cap_eff);
        end
      end
      CMD_PUSH_FRONT: begin
        if (free_c == '0) begin
          res_status_d = ST_FULL;
        end else begin
          rp_d      = (rp_q == '0) ? AW'(cap_eff - SW'(1)) : rp_q - AW'(1);
          ram_we    = 1'b1;
          ram_waddr = rp_d;
        end
      end
      CMD_POP: begin
        if (used_c == '0) begin
          res_status_d = ST_EMPTY;
        end else begin
          res_rd_d = 1'b1;
          rp_d     = wrap_add(rp_q, XW'(1), cap_eff);
        end
      end
      CMD_PEEK: begin
        ram_raddr = peek_addr;
        if (used_c == '0) begin
          res_status_d = ST_EMPTY;
        end else if (XW'(in_i.peek_offset) >= XW'(used_c)) begin
          res_status_d = ST_RANGE;
        end else begin
          res_rd_d = 1'b1;
        end
      end
      CMD_SKIP: begin
        rp_d = wrap_add(rp_q, skipped_c, cap_eff);
      end
      CMD_CLEAR: begin
        rp_d = '0;
        wp_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (wp_d >= rp_d) begin
      used_n = SW'(wp_d) - SW'(rp_d);
    end else begin
      used_n = SW'(wp_d) + cap_eff - SW'(rp_d);
    end
  end

  assign ram_re = accept && res_rd_d;

  // ---------------- state and result registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      res_rd_q    <= 1'b0;
    end else begin
      if (cfg_we) begin
        rp_q <= '0;
        wp_q <= '0;
      end else if (accept) begin
        rp_q <= rp_d;
        wp_q <= wp_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
        res_rd_q    <= res_rd_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q  <= res_status_d;
      res_skipped_q <= (cmd_e'(in_i.cmd) == CMD_SKIP) ? skipped_c : '0;
      res_used_q    <= used_n;
      res_free_q    <= cap_eff - used_n - SW'(1);
    end
  end

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = res_status_q;
  assign out_o.data_out      = res_rd_q ? ram_rdata : '0;
  assign out_o.bytes_skipped = res_skipped_q[COUNT_W-1:0];
  assign out_o.used_count    = COUNT_W'(res_used_q);
  assign out_o.free_count    = COUNT_W'(res_free_q);

  // ---------------- assertions ----------------
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(rp_q) < cap_eff) && (SW'(wp_q) < cap_eff))
    else $error("ring pointer at or beyond capacity");

  a_pop_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_e'(in_i.cmd) == CMD_POP && used_c != '0)
      |=> (res_used_q == $past(used_c) - SW'(1)))
    else $error("pop did not drop occupancy by one");

  a_full_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_status_q == ST_FULL) |-> (res_free_q == '0))
    else $error("full status reported with free space left");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (rp_q == '0 && wp_q == '0))
    else $error("capacity write did not empty the ring");

endmodule
